[design/blg_pkg.sv]
// Shared types and constants for the Bresenham line generator.
package blg_pkg;

	localparam int COORD_BITS     = 6;
	localparam int DEC_BITS       = COORD_BITS + 3;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

	// One classified line request, ready for stepping.
	typedef struct packed {
		logic   shallow;
		logic   minor_neg;
		coord_t maj0;
		coord_t min0;
		coord_t dmaj;
		coord_t dmin;
		dec_t   dec0;
	} blg_item_t;

	// Handshake from the stepping engine back to the queue.
	typedef struct packed {
		logic pop;
	} blg_qctl_t;

endpackage

[design/blg_front.sv]
// Front end: accepts a line request and classifies it for the stepping engine.
module blg_front (
	input  blg_pkg::coord_t    start_x,
	input  blg_pkg::coord_t    start_y,
	input  blg_pkg::coord_t    end_x,
	input  blg_pkg::coord_t    end_y,
	input  logic               start,
	input  logic               full,
	output logic               busy,
	output logic               push,
	output blg_pkg::blg_item_t item
);
	import blg_pkg::*;

	coord_t adx, ady;
	coord_t maj0, min0, maj1, min1;
	logic   shallow;
	logic   swap;
	dec_t   dmin_e, dmaj_e;

	// Accept a request whenever the queue has room
	assign busy = full;
	assign push = start & ~full;

	// Absolute deltas and major axis choice
	assign adx     = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
	assign ady     = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
	assign shallow = (ady < adx);
	assign swap    = shallow ? (start_x > end_x) : (start_y > end_y);

	// Order endpoints so the run goes up the major axis
	always_comb begin
		if (shallow) begin
			maj0 = swap ? end_x   : start_x;
			min0 = swap ? end_y   : start_y;
			maj1 = swap ? start_x : end_x;
			min1 = swap ? start_y : end_y;
		end else begin
			maj0 = swap ? end_y   : start_y;
			min0 = swap ? end_x   : start_x;
			maj1 = swap ? start_y : end_y;
			min1 = swap ? start_x : end_x;
		end
	end

	// Build the queue entry with the initial decision term
	always_comb begin
		item.shallow   = shallow;
		item.maj0      = maj0;
		item.min0      = min0;
		item.dmaj      = maj1 - maj0;
		item.minor_neg = (min1 < min0);
		item.dmin      = item.minor_neg ? (min0 - min1) : (min1 - min0);
		dmin_e         = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, item.dmin});
		dmaj_e         = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, item.dmaj});
		item.dec0      = (dmin_e <<< 1) - dmaj_e;
	end

endmodule

[design/blg_queue.sv]
// Short request queue between the front end and the stepping engine.
module blg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  blg_pkg::blg_item_t wr_item,
	output logic               full,
	input  blg_pkg::blg_qctl_t ctl_in,
	output logic               avail,
	output blg_pkg::blg_item_t rd_item
);
	import blg_pkg::*;

	blg_item_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      pop;

	assign full    = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign avail   = (count_q != '0);
	assign pop     = ctl_in.pop & avail;
	assign rd_item = mem_q[rd_ptr_q];

	// Store an incoming request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/blg_back.sv]
// Stepping engine: walks one queued line and emits a point per cycle.
module blg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  blg_pkg::blg_item_t item,
	output blg_pkg::blg_qctl_t ctl_out,
	output logic               point_valid,
	output blg_pkg::coord_t    point_x,
	output blg_pkg::coord_t    point_y,
	output logic               last_point
);
	import blg_pkg::*;

	logic   active_q;
	logic   shallow_q, neg_q;
	coord_t maj_q, min_q, dmaj_q, dmin_q, rem_q;
	dec_t   dec_q;
	logic   valid_q, last_q;
	coord_t px_q, py_q;

	logic   load;
	logic   done;
	dec_t   dmin_e, dmaj_e;

	assign done        = active_q & (rem_q == '0);
	assign load        = avail & (~active_q | done);
	assign ctl_out.pop = load;

	assign dmin_e = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, dmin_q});
	assign dmaj_e = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, dmaj_q});

	// Track whether a line is in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
			end else if (done) begin
				active_q <= 1'b0;
			end
		end
	end

	// Load a new line or advance one step along the current one
	always_ff @(posedge clk) begin
		if (load) begin
			shallow_q <= item.shallow;
			neg_q     <= item.minor_neg;
			maj_q     <= item.maj0;
			min_q     <= item.min0;
			dmaj_q    <= item.dmaj;
			dmin_q    <= item.dmin;
			rem_q     <= item.dmaj;
			dec_q     <= item.dec0;
		end else if (active_q) begin
			maj_q <= maj_q + 1'b1;
			rem_q <= rem_q - 1'b1;
			if (dec_q > dec_t'(0)) begin
				min_q <= neg_q ? (min_q - 1'b1) : (min_q + 1'b1);
				dec_q <= dec_q + ((dmin_e - dmaj_e) <<< 1);
			end else begin
				dec_q <= dec_q + (dmin_e <<< 1);
			end
		end
	end

	// Register the current point for output
	always_ff @(posedge clk) begin
		if (active_q) begin
			px_q   <= shallow_q ? maj_q : min_q;
			py_q   <= shallow_q ? min_q : maj_q;
			last_q <= (rem_q == '0);
		end
	end

	assign point_valid = valid_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign last_point  = last_q;

endmodule

[design/bresenham_line_generator_unit.sv]
// Bresenham line generator: emits every raster point between two endpoints.
// With the engine idle, a request's first point leaves via the queue, line and point registers.
// Throughput: |major delta| + 1 points per line (1 to 64), one point per cycle,
// set by the single stepping engine; queued lines follow each other with no gap.
// A two-entry queue takes requests while a line runs; busy is high when it is full.
// Reset (asynchronous, active low) empties the queue and stops any line; no result is held off.
module bresenham_line_generator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  blg_pkg::coord_t start_x,
	input  blg_pkg::coord_t start_y,
	input  blg_pkg::coord_t end_x,
	input  blg_pkg::coord_t end_y,
	output logic            point_valid,
	output blg_pkg::coord_t point_x,
	output blg_pkg::coord_t point_y,
	output logic            last_point
);
	import blg_pkg::*;

	blg_item_t push_item, pop_item;
	blg_qctl_t qctl;
	logic      push, full, avail;

	// Classify incoming requests
	blg_front u_front (
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.start   (start),
		.full    (full),
		.busy    (busy),
		.push    (push),
		.item    (push_item)
	);

	// Buffer classified requests
	blg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.full    (full),
		.ctl_in  (qctl),
		.avail   (avail),
		.rd_item (pop_item)
	);

	// Step each line out point by point
	blg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (avail),
		.item        (pop_item),
		.ctl_out     (qctl),
		.point_valid (point_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.last_point  (last_point)
	);

endmodule

[verif/testbench.sv]
// Self-checking testbench for the Bresenham line generator unit.
`timescale 1ns / 1ps

module testbench;

	import blg_pkg::*;

	localparam int MAX_COORD = (1 << COORD_BITS) - 1;

	typedef struct {
		coord_t x;
		coord_t y;
		logic   last;
	} raster_point_t;

	// Predict the raster points of each taken request and check emitted points in order.
	class line_scoreboard;
		raster_point_t pending_points[$];
		int mismatches;
		int lines_taken;
		int points_seen;
		int single_lines;
		int shallow_lines;
		int steep_lines;

		function new();
			mismatches    = 0;
			lines_taken   = 0;
			points_seen   = 0;
			single_lines  = 0;
			shallow_lines = 0;
			steep_lines   = 0;
		endfunction

		// Walk the line from the low to the high major coordinate.
		function void note_request(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
			int ax, ay, bx, by, adx, ady;
			int maj0, min0, maj1, min1, dmaj, dmin, dir, dec, minor, major;
			bit shallow;
			raster_point_t p;
			ax = sx;
			ay = sy;
			bx = ex;
			by = ey;
			adx = (ax > bx) ? ax - bx : bx - ax;
			ady = (ay > by) ? ay - by : by - ay;
			shallow = (ady < adx);
			if (shallow) begin
				if (ax > bx) begin
					maj0 = bx; min0 = by; maj1 = ax; min1 = ay;
				end else begin
					maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
				end
			end else begin
				if (ay > by) begin
					maj0 = by; min0 = bx; maj1 = ay; min1 = ax;
				end else begin
					maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
				end
			end
			dmaj = maj1 - maj0;
			dmin = min1 - min0;
			dir = 1;
			if (dmin < 0) begin
				dir = -1;
				dmin = -dmin;
			end
			dec = 2 * dmin - dmaj;
			minor = min0;
			for (int k = 0; k <= dmaj; k++) begin
				major = maj0 + k;
				p.x = shallow ? coord_t'(major) : coord_t'(minor);
				p.y = shallow ? coord_t'(minor) : coord_t'(major);
				p.last = (k == dmaj);
				pending_points = {pending_points, p};
				// Move the minor coordinate only on a positive decision term
				if (dec > 0) begin
					minor += dir;
					dec += 2 * (dmin - dmaj);
				end else begin
					dec += 2 * dmin;
				end
			end
			lines_taken++;
			if (dmaj == 0)
				single_lines++;
			else if (shallow)
				shallow_lines++;
			else
				steep_lines++;
		endfunction

		// Compare one emitted point with the oldest expected point.
		function void check_point(coord_t x, coord_t y, logic last);
			raster_point_t p;
			points_seen++;
			if (pending_points.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected point x=%0d y=%0d last=%0b", $time, x, y, last);
				return;
			end
			p = pending_points.pop_front();
			if (x !== p.x) begin
				mismatches++;
				$display("%0t: point_x expected %0d actual %0d", $time, p.x, x);
			end
			if (y !== p.y) begin
				mismatches++;
				$display("%0t: point_y expected %0d actual %0d", $time, p.y, y);
			end
			if (last !== p.last) begin
				mismatches++;
				$display("%0t: last_point expected %0b actual %0b", $time, p.last, last);
			end
		endfunction

		// Flag any points that never showed up.
		function void check_drained();
			if (pending_points.size() != 0) begin
				mismatches++;
				$display("%0t: %0d expected points never emitted, next x=%0d y=%0d",
					$time, pending_points.size(), pending_points[0].x, pending_points[0].y);
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	logic   point_valid;
	coord_t point_x;
	coord_t point_y;
	logic   last_point;

	line_scoreboard sb = new();

	bresenham_line_generator_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.point_valid (point_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.last_point  (last_point)
	);

	// Free-running 50 MHz clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Check every strobed point
	always @(posedge clk) begin
		if (arst_n && point_valid)
			sb.check_point(point_x, point_y, last_point);
	end

	// Hold the request until the block takes it, then log the expected points.
	task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
			input coord_t ey);
		start   <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		end_x   <= ex;
		end_y   <= ey;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(sx, sy, ex, ey);
	endtask

	// Drop the request line now and then, with junk on the fields.
	task automatic idle_gap(input int pct);
		int cycles;
		if ($urandom_range(99) < pct) begin
			cycles = $urandom_range(1, 8);
			start   <= 1'b0;
			start_x <= coord_t'($urandom);
			start_y <= coord_t'($urandom);
			end_x   <= coord_t'($urandom);
			end_y   <= coord_t'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Build a diagonal or near-diagonal line, then mirror, transpose and swap at random.
	task automatic send_shaped(input int extra);
		int len, x0, y0, x1, y1, t;
		len = $urandom_range(0, MAX_COORD - 1);
		x0 = $urandom_range(0, MAX_COORD - len - extra);
		y0 = $urandom_range(0, MAX_COORD - len);
		x1 = x0 + len + extra;
		y1 = y0 + len;
		if ($urandom_range(1)) begin
			x0 = MAX_COORD - x0;
			x1 = MAX_COORD - x1;
		end
		if ($urandom_range(1)) begin
			y0 = MAX_COORD - y0;
			y1 = MAX_COORD - y1;
		end
		if ($urandom_range(1)) begin
			t = x0; x0 = y0; y0 = t;
			t = x1; x1 = y1; y1 = t;
		end
		if ($urandom_range(1))
			send_line(coord_t'(x1), coord_t'(y1), coord_t'(x0), coord_t'(y0));
		else
			send_line(coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1));
	endtask

	// Pick a random line from a mix of shapes.
	task automatic send_random_line();
		int kind;
		coord_t sx, sy;
		kind = $urandom_range(9);
		sx = coord_t'($urandom);
		sy = coord_t'($urandom);
		case (kind)
			5, 6: begin
				send_line(sx, sy, coord_t'(sx + $urandom_range(0, 6) - 3),
					coord_t'(sy + $urandom_range(0, 6) - 3));
			end
			7: begin
				send_shaped(0);
			end
			8: begin
				if ($urandom_range(1))
					send_line(sx, sy, coord_t'($urandom), sy);
				else
					send_line(sx, sy, sx, coord_t'($urandom));
			end
			9: begin
				send_shaped(1);
			end
			default: begin
				send_line(sx, sy, coord_t'($urandom), coord_t'($urandom));
			end
		endcase
	endtask

	// Abort a hung run
	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d points outstanding", $time, sb.pending_points.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int idle_pct[4];
		int waited;
		idle_pct = '{0, 60, 33, 0};
		arst_n  = 1'b0;
		start   <= 1'b0;
		start_x <= '0;
		start_y <= '0;
		end_x   <= '0;
		end_y   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: equal endpoints, full-range axes and diagonals, every octant
		send_line(6'd0, 6'd0, 6'd0, 6'd0);
		send_line(6'd63, 6'd63, 6'd63, 6'd63);
		send_line(6'd0, 6'd0, 6'd63, 6'd0);
		send_line(6'd63, 6'd63, 6'd0, 6'd63);
		send_line(6'd0, 6'd0, 6'd0, 6'd63);
		send_line(6'd63, 6'd63, 6'd63, 6'd0);
		send_line(6'd0, 6'd0, 6'd63, 6'd63);
		send_line(6'd63, 6'd63, 6'd0, 6'd0);
		send_line(6'd63, 6'd0, 6'd0, 6'd63);
		send_line(6'd0, 6'd63, 6'd63, 6'd0);
		send_line(6'd10, 6'd10, 6'd30, 6'd17);
		send_line(6'd10, 6'd10, 6'd17, 6'd30);
		send_line(6'd10, 6'd10, 6'd3, 6'd30);
		send_line(6'd10, 6'd10, 6'd0, 6'd13);
		send_line(6'd40, 6'd40, 6'd20, 6'd33);
		send_line(6'd40, 6'd40, 6'd33, 6'd20);
		send_line(6'd40, 6'd40, 6'd47, 6'd20);
		send_line(6'd40, 6'd40, 6'd60, 6'd37);
		send_line(6'd0, 6'd0, 6'd63, 6'd62);
		send_line(6'd0, 6'd0, 6'd62, 6'd63);
		send_line(6'd5, 6'd9, 6'd6, 6'd9);
		send_line(6'd5, 6'd9, 6'd6, 6'd10);
		send_line(6'd42, 6'd21, 6'd21, 6'd42);

		// Random lines, one phase per idling mix
		foreach (idle_pct[ph]) begin
			for (int i = 0; i < 50; i++) begin
				send_random_line();
				idle_gap(idle_pct[ph]);
			end
		end
		start <= 1'b0;

		// Drain the last lines, then allow the pipeline to settle
		waited = 0;
		while (sb.pending_points.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		sb.check_drained();

		$display("Ran %0d line requests (%0d single-point, %0d shallow, %0d steep), %0d points",
			sb.lines_taken, sb.single_lines, sb.shallow_lines, sb.steep_lines, sb.points_seen);
		$display("Idle mixes: none, sender 60%%, sender 33%%, none; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
